/* hdl/hbmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbmt_pkg
// Shared constants, codes and types of the bucketed hash match table.
// ----------------------------------------------------------------------------
package hbmt_pkg;

  localparam int BUCKETS      = 1024;
  localparam int SLOTS        = 8;
  localparam int KEY_CHARS    = 5;
  localparam int PAYLOAD_BITS = 16;
  localparam int CODE_BITS    = 5;
  localparam int KEY_BITS     = KEY_CHARS * CODE_BITS;
  localparam int HASH_BASE    = 29;
  localparam int LAST_LETTER  = 26;
  localparam int CFG_W        = 11;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 3;
  localparam int BUCKET_W     = $clog2(BUCKETS);
  // base-29 sum over 5-bit codes stays below 32**KEY_CHARS
  localparam int ACC_W        = KEY_BITS;
  localparam int CNT_W        = $clog2(ACC_W);
  localparam int IN_TDATA_W   = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((PAYLOAD_BITS + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(BUCKETS);

  localparam logic [REQ_W-1:0] REQ_TAKE     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TAKE_INS = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_TAKEN     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef struct packed {
    logic                    valid;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

  typedef slot_t [SLOTS-1:0] row_t;

  typedef struct packed {
    logic                load;
    logic                hash_step;
    logic                mod_step;
    logic                rd;
    logic                wr;
    logic                out_load;
    logic                clr;
    logic [BUCKET_W-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic bad;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/bucketed_hash_match_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_hash_match_table_unit
// Hash table of 1024 buckets by 8 slots with take, insert and take-else-insert.
// ----------------------------------------------------------------------------
// After reset the unit clears its bucket memory, one bucket per cycle, over all
// 1024 buckets; in_tready stays low during that pass. A valid-key request then
// goes from acceptance through five hash steps (one letter code each), 25 steps
// of the bit-serial remainder by the bucket count, one bucket read and a final
// step of slot match, update and result load, which waits while an untaken
// result still sits in the output register. An invalid key skips from the first
// hash step to that final step. The result sits in an output register, so the
// next transaction can be taken while it waits.
module bucketed_hash_match_table_unit
  import hbmt_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // key[24:0], payload[40:25], zero fill
  input  wire [REQ_W-1:0]        in_tuser,   // req_type[1:0]
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // found_payload[15:0]
  output logic [STATUS_W-1:0]    out_tuser,  // status[2:0]
  input  wire                    cfg_wen,
  input  wire [CFG_W-1:0]        cfg_wdata
);

  cmd_t                    cmd;
  sts_t                    sts;
  logic [PAYLOAD_BITS-1:0] found_payload;

  hbmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hbmt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req      (in_tuser),
    .in_key      (in_tdata[KEY_BITS-1:0]),
    .in_payload  (in_tdata[KEY_BITS +: PAYLOAD_BITS]),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .out_status  (out_tuser),
    .out_payload (found_payload)
  );

  assign out_tdata = OUT_TDATA_W'(found_payload);

  // one transaction in flight: no acceptance right after another
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is in flight");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= STATUS_W'(ST_INVALID)))
    else $error("status code out of range");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STATUS_W'(ST_TAKEN)) |-> (out_tdata == '0))
    else $error("payload returned without a take");

  // a fresh result only appears after a finished request, never during the clear
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised while idle");

endmodule
`default_nettype wire

/* hdl/hbmt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbmt_ctrl
// Sequencer: clearing pass, hash steps, remainder steps, bucket read and
// update, result handoff.
// ----------------------------------------------------------------------------
module hbmt_ctrl
  import hbmt_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_READ,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BUCKET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    clr_cnt_nxt  = clr_cnt_r;
    cmd          = '0;
    cmd.clr_addr = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr     = 1'b1;
        cmd.wr      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BUCKET_W'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.bad) begin
          state_nxt = S_FIN;
        end else begin
          cmd.hash_step = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(KEY_CHARS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.wr       = !sts.bad;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/hbmt_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbmt_dp
// Datapath: key check, base-29 hash, bit-serial remainder, bucket memory and
// slot match / fill logic with the result register.
// ----------------------------------------------------------------------------
module hbmt_dp
  import hbmt_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  wire [REQ_W-1:0]         in_req,
  input  wire [KEY_BITS-1:0]      in_key,
  input  wire [PAYLOAD_BITS-1:0]  in_payload,
  input  wire                     cfg_wen,
  input  wire [CFG_W-1:0]         cfg_wdata,
  output logic [STATUS_W-1:0]     out_status,
  output logic [PAYLOAD_BITS-1:0] out_payload
);

  localparam logic [ACC_W-1:0] HASH_MUL = ACC_W'(HASH_BASE);

  logic [CFG_W-1:0]        bucket_count_r;
  logic [CFG_W-1:0]        mod_clamp;
  logic [REQ_W-1:0]        req_r;
  logic [KEY_BITS-1:0]     norm_key, norm_r, work_r;
  logic [KEY_CHARS-1:0]    kept, kept_r;
  logic                    key_bad, bad_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [ACC_W-1:0]        acc_r;
  logic [CFG_W-1:0]        rem_r, mod_r;
  logic [CFG_W:0]          rem_trial;
  logic [BUCKET_W-1:0]     bucket;
  row_t                    mem [BUCKETS];
  row_t                    rd_row_r, new_row, wr_row;
  logic [BUCKET_W-1:0]     wr_addr;
  status_t                 res_status;
  logic [PAYLOAD_BITS-1:0] res_found;
  logic [STATUS_W-1:0]     out_status_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RST;
    end else if (cfg_wen) begin
      bucket_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    mod_clamp = bucket_count_r;
    if (bucket_count_r == '0) begin
      mod_clamp = CFG_W'(1);
    end else if (bucket_count_r > CFG_W'(BUCKETS)) begin
      mod_clamp = CFG_W'(BUCKETS);
    end
  end

  // codes after the first zero code are dropped from key and hash
  always_comb begin
    logic                 ended;
    logic [CODE_BITS-1:0] code;
    ended    = 1'b0;
    key_bad  = 1'b0;
    kept     = '0;
    norm_key = '0;
    code     = '0;
    for (int i = KEY_CHARS - 1; i >= 0; i--) begin
      code = in_key[i*CODE_BITS +: CODE_BITS];
      if (!ended) begin
        if (code == '0) begin
          if (i == KEY_CHARS - 1) begin
            key_bad = 1'b1;
          end
          ended = 1'b1;
        end else begin
          if (code > CODE_BITS'(LAST_LETTER)) begin
            key_bad = 1'b1;
          end
          kept[i] = 1'b1;
          norm_key[i*CODE_BITS +: CODE_BITS] = code;
        end
      end
    end
  end

  assign rem_trial = {rem_r, acc_r[ACC_W-1]};
  assign bucket    = rem_r[BUCKET_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req;
      norm_r <= norm_key;
      work_r <= norm_key;
      kept_r <= kept;
      bad_r  <= key_bad;
      pay_r  <= in_payload;
      acc_r  <= '0;
      rem_r  <= '0;
      mod_r  <= mod_clamp;
    end else if (cmd.hash_step) begin
      if (kept_r[KEY_CHARS-1]) begin
        acc_r <= acc_r * HASH_MUL + ACC_W'(work_r[KEY_BITS-1 -: CODE_BITS]);
      end
      work_r <= work_r << CODE_BITS;
      kept_r <= kept_r << 1;
    end else if (cmd.mod_step) begin
      // restoring remainder, one dividend bit per step, msb first
      if (rem_trial >= {1'b0, mod_r}) begin
        rem_r <= CFG_W'(rem_trial - {1'b0, mod_r});
      end else begin
        rem_r <= CFG_W'(rem_trial);
      end
      acc_r <= acc_r << 1;
    end
  end

  assign sts.bad = bad_r;

  always_comb begin
    logic hit;
    logic placed;
    new_row    = rd_row_r;
    res_status = ST_NOT_FOUND;
    res_found  = '0;
    hit        = 1'b0;
    placed     = 1'b0;
    if (req_r == REQ_TAKE || req_r == REQ_TAKE_INS) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit && rd_row_r[i].valid && rd_row_r[i].key == norm_r) begin
          hit        = 1'b1;
          res_found  = rd_row_r[i].payload;
          new_row[i] = '0;
        end
      end
      if (hit) begin
        res_status = ST_TAKEN;
      end
    end
    if (req_r == REQ_INSERT || (req_r == REQ_TAKE_INS && !hit)) begin
      res_status = ST_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !rd_row_r[i].valid) begin
          placed     = 1'b1;
          new_row[i] = '{valid: 1'b1, key: norm_r, payload: pay_r};
        end
      end
      if (placed) begin
        res_status = ST_INSERTED;
      end
    end
    if (bad_r) begin
      res_status = ST_INVALID;
      res_found  = '0;
    end
  end

  assign wr_row  = cmd.clr ? row_t'('0) : new_row;
  assign wr_addr = cmd.clr ? cmd.clr_addr : bucket;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd) begin
      rd_row_r <= mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r  <= res_status;
      out_payload_r <= res_found;
    end
  end

  assign out_status  = out_status_r;
  assign out_payload = out_payload_r;

endmodule
`default_nettype wire
